@@ rtl/tpd_pkg.sv @@
// Shared types and constants for the touch packet decoder.
// Holds the byte codes of the serial protocol and the result record.
// No dependencies.
package tpd_pkg;

    // Input item kinds carried on s_tuser.
    localparam logic IN_SERIAL_BYTE = 1'b0;
    localparam logic IN_ARM_RESPONSE = 1'b1;

    // Result kinds carried on m_tuser.
    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_RESPONSE = 2'd2;

    // Protocol byte codes.
    localparam logic [7:0] HDR_PEN_DOWN = 8'hFF;
    localparam logic [7:0] HDR_PEN_UP = 8'hBF;
    localparam logic [7:0] SHORT_CODE_A = 8'hFE;
    localparam logic [7:0] SHORT_CODE_B = 8'hFD;
    localparam logic [7:0] RESP_SYNC = 8'hFF;

    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic        pen_down;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [7:0]  code_first;
        logic [7:0]  code_second;
        logic        pressed;
        logic        released;
    } result_t;

    // Packs the result fields except packet_kind into tdata, pen_down in the lowest bit.
    function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
        logic [OUT_DATA_W-1:0] d;
        d = '0;
        d[0]     = r.pen_down;
        d[16:1]  = r.x_pos;
        d[32:17] = r.y_pos;
        d[40:33] = r.code_first;
        d[48:41] = r.code_second;
        d[49]    = r.pressed;
        d[50]    = r.released;
        return d;
    endfunction

endpackage

@@ rtl/touch_packet_decoder.sv @@
// Touch packet decoder: frames serial bytes from a touch controller into
// position reports, short status packets and command responses.
// A result is registered in the output register, or in the skid stage.
// Throughput: one item per cycle while the skid stage is empty; a two-entry
// output register and skid stage keep s_tready high while one result waits.
// Reset (aresetn low, synchronous) returns to header search with the pen up.
module touch_packet_decoder
    import tpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] pen_down, [16:1] x_pos, [32:17] y_pos, [40:33] code_first,
    // [48:41] code_second, [49] pressed, [50] released, [55:51] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser    // [1:0] packet_kind
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_B1,
        PH_B2,
        PH_B3,
        PH_B4,
        PH_RSKIP,
        PH_RC1,
        PH_RC2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_reg, header_next;
    logic [7:0]  x_high_reg, x_high_next;
    logic [7:0]  x_low_reg, x_low_next;
    logic [7:0]  y_high_reg, y_high_next;
    logic        pen_reg, pen_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg, out_res_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_res_reg, skid_res_next;

    logic        in_fire;
    logic        out_free;
    logic        new_valid;
    result_t     new_res;
    logic        pen_now;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign pen_now  = (header_reg == HDR_PEN_DOWN);

    // Parser: one byte per accepted item.
    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_high_next = x_high_reg;
        x_low_next  = x_low_reg;
        y_high_next = y_high_reg;
        pen_next    = pen_reg;
        new_valid   = 1'b0;
        new_res     = '0;

        if (in_fire) begin
            if (s_tuser == IN_ARM_RESPONSE) begin
                phase_next = PH_RSKIP;
            end else begin
                unique case (phase_reg)
                    PH_HDR: begin
                        if (s_tdata == HDR_PEN_DOWN || s_tdata == HDR_PEN_UP) begin
                            header_next = s_tdata;
                            phase_next  = PH_B1;
                        end
                    end
                    PH_B1: begin
                        x_high_next = s_tdata;
                        phase_next  = PH_B2;
                    end
                    PH_B2: begin
                        x_low_next = s_tdata;
                        if ((x_high_reg == SHORT_CODE_A && s_tdata == SHORT_CODE_A) ||
                            (x_high_reg == SHORT_CODE_B && s_tdata == SHORT_CODE_B)) begin
                            phase_next          = PH_HDR;
                            pen_next            = pen_now;
                            new_valid           = 1'b1;
                            new_res.packet_kind = KIND_SHORT;
                            new_res.pen_down    = pen_now;
                            new_res.code_first  = x_high_reg;
                            new_res.code_second = s_tdata;
                            new_res.pressed     = !pen_reg && pen_now;
                            new_res.released    = pen_reg && !pen_now;
                        end else begin
                            phase_next = PH_B3;
                        end
                    end
                    PH_B3: begin
                        y_high_next = s_tdata;
                        phase_next  = PH_B4;
                    end
                    PH_B4: begin
                        phase_next          = PH_HDR;
                        pen_next            = pen_now;
                        new_valid           = 1'b1;
                        new_res.packet_kind = KIND_REPORT;
                        new_res.pen_down    = pen_now;
                        new_res.x_pos       = {x_high_reg, x_low_reg};
                        new_res.y_pos       = {y_high_reg, s_tdata};
                        new_res.pressed     = !pen_reg && pen_now;
                        new_res.released    = pen_reg && !pen_now;
                    end
                    PH_RSKIP: begin
                        if (s_tdata == RESP_SYNC) begin
                            phase_next = PH_RC1;
                        end
                    end
                    PH_RC1: begin
                        x_high_next = s_tdata;
                        phase_next  = PH_RC2;
                    end
                    PH_RC2: begin
                        phase_next          = PH_HDR;
                        new_valid           = 1'b1;
                        new_res.packet_kind = KIND_RESPONSE;
                        new_res.pen_down    = pen_reg;
                        new_res.code_first  = x_high_reg;
                        new_res.code_second = s_tdata;
                    end
                endcase
            end
        end
    end

    // Output register with a skid stage behind it. A new result only arrives
    // when the skid stage is empty, so it never overwrites a waiting one.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;

        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = new_valid;
                skid_res_next   = new_res;
            end else begin
                out_valid_next = new_valid;
                out_res_next   = new_res;
            end
        end else if (new_valid) begin
            skid_valid_next = 1'b1;
            skid_res_next   = new_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR;
            header_reg     <= '0;
            x_high_reg     <= '0;
            x_low_reg      <= '0;
            y_high_reg     <= '0;
            pen_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            header_reg     <= header_next;
            x_high_reg     <= x_high_next;
            x_low_reg      <= x_low_next;
            y_high_reg     <= y_high_next;
            pen_reg        <= pen_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pack_result(out_res_reg);
    assign m_tuser  = out_res_reg.packet_kind;

    // The skid stage only fills behind a waiting output result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    // A pen edge can only go one way, and a press leaves the pen down.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_res_reg.pressed && out_res_reg.released) &&
                          (!out_res_reg.pressed || out_res_reg.pen_down))
        else $error("inconsistent pen edge flags");

    // Command responses never report pen edges or coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.packet_kind == KIND_RESPONSE) |->
            !out_res_reg.pressed && !out_res_reg.released &&
            out_res_reg.x_pos == '0 && out_res_reg.y_pos == '0)
        else $error("command response carries pen or position data");

    // Reset empties both result stages.
    assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !skid_valid_reg)
        else $error("result stages not cleared by reset");

endmodule

@@ test/tpd_checker.sv @@
// Scoreboard for the touch packet decoder: watches both stream channels,
// decodes each accepted input item and compares every result field by field.
// Depends on tpd_pkg for the result record and the protocol byte codes.
module tpd_checker
    import tpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    output int                    mismatch_count,
    output int                    results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SEEK_HDR,
        TAKE_XH,
        TAKE_XL,
        TAKE_YH,
        TAKE_YL,
        SEEK_SYNC,
        TAKE_CODE1,
        TAKE_CODE2
    } frame_phase_t;

    frame_phase_t phase;
    logic [7:0]   hdr;
    logic [7:0]   xh;
    logic [7:0]   xl;
    logic [7:0]   yh;
    logic         pen;
    result_t      decoded_q[$];

    initial begin
        mismatch_count = 0;
        results_owed = 0;
    end

    task automatic report(input string field, input longint got, input longint want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Pen state follows the stored header; returns {pressed, released}.
    function automatic logic [1:0] follow_pen();
        logic now_down;
        logic [1:0] edges;
        now_down = (hdr == HDR_PEN_DOWN);
        edges = {!pen && now_down, pen && !now_down};
        pen = now_down;
        return edges;
    endfunction

    task automatic decode_item(input logic kind, input logic [7:0] b);
        result_t r;
        logic [1:0] edges;
        r = '0;
        if (kind == IN_ARM_RESPONSE) begin
            phase = SEEK_SYNC;
            return;
        end
        case (phase)
            SEEK_HDR: begin
                if (b == HDR_PEN_DOWN || b == HDR_PEN_UP) begin
                    hdr = b;
                    phase = TAKE_XH;
                end
            end
            TAKE_XH: begin
                xh = b;
                phase = TAKE_XL;
            end
            TAKE_XL: begin
                xl = b;
                if ((xh == SHORT_CODE_A && b == SHORT_CODE_A) ||
                    (xh == SHORT_CODE_B && b == SHORT_CODE_B)) begin
                    edges = follow_pen();
                    r.packet_kind = KIND_SHORT;
                    r.pen_down = pen;
                    r.code_first = xh;
                    r.code_second = b;
                    r.pressed = edges[1];
                    r.released = edges[0];
                    decoded_q.push_back(r);
                    phase = SEEK_HDR;
                end else begin
                    phase = TAKE_YH;
                end
            end
            TAKE_YH: begin
                yh = b;
                phase = TAKE_YL;
            end
            TAKE_YL: begin
                edges = follow_pen();
                r.packet_kind = KIND_REPORT;
                r.pen_down = pen;
                r.x_pos = {xh, xl};
                r.y_pos = {yh, b};
                r.pressed = edges[1];
                r.released = edges[0];
                decoded_q.push_back(r);
                phase = SEEK_HDR;
            end
            SEEK_SYNC: begin
                if (b == RESP_SYNC) begin
                    phase = TAKE_CODE1;
                end
            end
            TAKE_CODE1: begin
                xh = b;
                phase = TAKE_CODE2;
            end
            default: begin
                r.packet_kind = KIND_RESPONSE;
                r.pen_down = pen;
                r.code_first = xh;
                r.code_second = b;
                decoded_q.push_back(r);
                phase = SEEK_HDR;
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            phase = SEEK_HDR;
            hdr = '0;
            xh = '0;
            xl = '0;
            yh = '0;
            pen = 1'b0;
            decoded_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    report("unexpected result, packet_kind", m_tuser, 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser != want.packet_kind)
                        report("packet_kind", m_tuser, want.packet_kind);
                    if (m_tdata[0] != want.pen_down)
                        report("pen_down", m_tdata[0], want.pen_down);
                    if (m_tdata[16:1] != want.x_pos)
                        report("x_pos", m_tdata[16:1], want.x_pos);
                    if (m_tdata[32:17] != want.y_pos)
                        report("y_pos", m_tdata[32:17], want.y_pos);
                    if (m_tdata[40:33] != want.code_first)
                        report("code_first", m_tdata[40:33], want.code_first);
                    if (m_tdata[48:41] != want.code_second)
                        report("code_second", m_tdata[48:41], want.code_second);
                    if (m_tdata[49] != want.pressed)
                        report("pressed", m_tdata[49], want.pressed);
                    if (m_tdata[50] != want.released)
                        report("released", m_tdata[50], want.released);
                    if (m_tdata[OUT_DATA_W-1:51] != '0)
                        report("tdata padding", m_tdata[OUT_DATA_W-1:51], 0);
                end
            end
            if (s_tvalid && s_tready) begin
                decode_item(s_tuser, s_tdata);
            end
        end
        results_owed = decoded_q.size();
    end

endmodule

@@ test/tb_top.sv @@
// Top of the touch packet decoder testbench: clock, reset, byte stimulus,
// result back-pressure, watchdog and verdict.
// Depends on tpd_pkg, the touch_packet_decoder RTL and tpd_checker.
module tb_top;
    import tpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RESULT_HOLD = 400;
    localparam int RANDOM_ITEMS = 1000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = IN_SERIAL_BYTE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    int                    mismatch_count;
    int                    results_owed;
    int                    quiet_cycles = 0;
    int                    sent_items = 0;
    bit                    tx_idle = 1'b1;

    always #5 aclk = ~aclk;

    touch_packet_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tpd_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Called at a falling edge; returns at the falling edge after acceptance.
    // With no gap, tvalid simply stays high into the next item.
    task automatic send_item(input logic kind, input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_items++;
        if ($urandom_range(0, 99) == 0) tx_idle = !tx_idle;
    endtask

    // One framed sequence, mostly well formed, sometimes noise or cut short.
    task automatic send_sequence();
        int pick;
        int n;
        logic [7:0] hdr;
        logic [7:0] b1;
        logic [7:0] b2;
        pick = $urandom_range(0, 99);
        hdr = $urandom_range(0, 1) ? HDR_PEN_DOWN : HDR_PEN_UP;
        if (pick < 50) begin
            if ($urandom_range(0, 9) == 0) hdr = 8'($urandom_range(0, 255));
            b1 = 8'($urandom_range(0, 255));
            b2 = 8'($urandom_range(0, 255));
            // Near misses of the short-packet code pairs.
            if ($urandom_range(0, 7) == 0) begin
                b1 = $urandom_range(0, 1) ? SHORT_CODE_A : SHORT_CODE_B;
                b2 = (b1 == SHORT_CODE_A) ? SHORT_CODE_B : SHORT_CODE_A;
            end
            send_item(IN_SERIAL_BYTE, hdr);
            send_item(IN_SERIAL_BYTE, b1);
            send_item(IN_SERIAL_BYTE, b2);
            send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
            send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
        end else if (pick < 70) begin
            b1 = $urandom_range(0, 1) ? SHORT_CODE_A : SHORT_CODE_B;
            send_item(IN_SERIAL_BYTE, hdr);
            send_item(IN_SERIAL_BYTE, b1);
            send_item(IN_SERIAL_BYTE, b1);
        end else if (pick < 85) begin
            send_item(IN_ARM_RESPONSE, 8'($urandom_range(0, 255)));
            n = $urandom_range(0, 3);
            repeat (n) send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
            send_item(IN_SERIAL_BYTE, RESP_SYNC);
            send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
            send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_item(($urandom_range(0, 7) == 0) ? IN_ARM_RESPONSE : IN_SERIAL_BYTE,
                          8'($urandom_range(0, 255)));
            end
        end else begin
            // A report broken off by an arm event, finished as a response.
            send_item(IN_SERIAL_BYTE, hdr);
            n = $urandom_range(1, 3);
            repeat (n) send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
            send_item(IN_ARM_RESPONSE, 8'($urandom_range(0, 255)));
            send_item(IN_SERIAL_BYTE, RESP_SYNC);
            send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
            send_item(IN_SERIAL_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Report of all zeros straight after reset: pen goes down.
        send_item(IN_SERIAL_BYTE, HDR_PEN_DOWN);
        repeat (4) send_item(IN_SERIAL_BYTE, 8'h00);
        // Short packet with the first code pair: pen goes up.
        send_item(IN_SERIAL_BYTE, HDR_PEN_UP);
        send_item(IN_SERIAL_BYTE, SHORT_CODE_A);
        send_item(IN_SERIAL_BYTE, SHORT_CODE_A);
        // Unknown header is dropped.
        send_item(IN_SERIAL_BYTE, 8'h7F);
        // Report with every coordinate bit set.
        send_item(IN_SERIAL_BYTE, HDR_PEN_DOWN);
        repeat (4) send_item(IN_SERIAL_BYTE, 8'hFF);
        // Arm in the middle of a report; the arm's data byte is ignored.
        send_item(IN_SERIAL_BYTE, HDR_PEN_DOWN);
        send_item(IN_SERIAL_BYTE, 8'h12);
        send_item(IN_ARM_RESPONSE, RESP_SYNC);
        send_item(IN_SERIAL_BYTE, 8'h34);
        send_item(IN_SERIAL_BYTE, RESP_SYNC);
        send_item(IN_SERIAL_BYTE, 8'hAA);
        send_item(IN_SERIAL_BYTE, 8'h55);
        // Short packet with the second code pair: pen goes up again.
        send_item(IN_SERIAL_BYTE, HDR_PEN_UP);
        send_item(IN_SERIAL_BYTE, SHORT_CODE_B);
        send_item(IN_SERIAL_BYTE, SHORT_CODE_B);

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) send_sequence();

        s_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Result side: random waits per item, and two long hold-offs that let
    // the decoder fill up and push back on its input.
    initial begin : receiver
        int hold;
        int served;
        bit rx_idle;
        served = 0;
        rx_idle = 1'b1;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (served == 30 || served == 150) begin
                hold = RESULT_HOLD;
            end else begin
                hold = rx_idle ? $urandom_range(0, 15) : 0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
            served++;
            if (served % 50 == 0) rx_idle = 1'($urandom_range(0, 1));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
rtl/tpd_pkg.sv
rtl/touch_packet_decoder.sv
test/tpd_checker.sv
test/tb_top.sv
